// ----- rtl/abe_pkg.sv -----
package abe_pkg;

  // Operation of one parsed line, settled by the front end.
  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_MOD,
    OP_BAD
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DIV0  = 2'd1,
    ST_MOD0  = 2'd2,
    ST_BADOP = 2'd3
  } status_e;

  // Control part of one job handed from the parser to the execution unit.
  typedef struct packed {
    op_e op;
  } job_ctl_t;

endpackage

// ----- rtl/ascii_binary_expression_evaluator_top.sv -----
// Channel  | Direction | Handshake         | Beat payload
// ---------+-----------+-------------------+---------------------------------
// input    | in        | push / full       | char_code_i (8b, 0 ends a line)
// result   | out       | pop / empty       | value_o (32b signed), status_o (2b)
//
// A character beat is taken whenever push is high and full is low; the parser never stalls on its own.
// A line's end hands a job to a two-deep queue; full rises only when two jobs wait.
// Execution: + - unknown and zero divisor go straight to the result stage, * runs
// a shift-add multiplier (one bit a cycle), / and % a restoring divider (one bit
// a cycle), then a sign fix-up step.
// Reset is asynchronous, active low, and returns the parser to the leading-space
// phase with empty queue and no pending result; no clearing pass follows.
// A result held for pop stalls the execution unit; once two jobs wait behind it,
// full rises and holds the input side too.
module ascii_binary_expression_evaluator_top import abe_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  input  logic [7:0]         char_code_i,
  output logic               full,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] value_o,
  output logic [1:0]         status_o
);

  localparam int VALUE_W = 32;
  localparam int JOB_W   = 2 * DATA_WIDTH + $bits(job_ctl_t);

  logic                  char_valid;
  logic                  fe_valid;
  job_ctl_t              fe_ctl;
  logic [DATA_WIDTH-1:0] fe_a, fe_b;

  logic                  q_valid, q_pop;
  logic [JOB_W-1:0]      q_rdata;
  job_ctl_t              q_ctl;
  logic [DATA_WIDTH-1:0] q_a, q_b;

  logic                  res_valid;
  logic [DATA_WIDTH-1:0] res_value;
  status_e               res_status;

  // accept a character beat only while the job queue has room
  assign char_valid = push && !full;

  abe_front #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .char_valid_i (char_valid),
    .char_code_i  (char_code_i),
    .job_valid_o  (fe_valid),
    .job_ctl_o    (fe_ctl),
    .job_a_o      (fe_a),
    .job_b_o      (fe_b)
  );

  abe_queue #(
    .WIDTH (JOB_W)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fe_valid),
    .wdata_i ({fe_ctl, fe_a, fe_b}),
    .full_o  (full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rdata_o (q_rdata)
  );

  assign {q_ctl, q_a, q_b} = q_rdata;

  abe_back #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_valid_i  (q_valid),
    .job_ctl_i    (q_ctl),
    .job_a_i      (q_a),
    .job_b_i      (q_b),
    .job_pop_o    (q_pop),
    .out_valid_o  (res_valid),
    .out_pop_i    (pop && res_valid),
    .out_value_o  (res_value),
    .out_status_o (res_status)
  );

  // low 32 bits of the result; narrower data widths zero-extend
  assign empty    = !res_valid;
  assign value_o  = VALUE_W'(res_value);
  assign status_o = res_status;

endmodule

// ----- rtl/abe_front.sv -----
module abe_front import abe_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  char_valid_i,
  input  logic [7:0]            char_code_i,
  output logic                  job_valid_o,
  output job_ctl_t              job_ctl_o,
  output logic [DATA_WIDTH-1:0] job_a_o,
  output logic [DATA_WIDTH-1:0] job_b_o
);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;

  localparam logic [2:0] PH_LEAD  = 3'd0;
  localparam logic [2:0] PH_DIG1  = 3'd1;
  localparam logic [2:0] PH_PREOP = 3'd2;
  localparam logic [2:0] PH_LEAD2 = 3'd3;
  localparam logic [2:0] PH_DIG2  = 3'd4;
  localparam logic [2:0] PH_REST  = 3'd5;

  logic [2:0]            phase_q, phase_d;
  logic [DATA_WIDTH-1:0] first_q, first_d;
  logic [DATA_WIDTH-1:0] second_q, second_d;
  logic                  neg_q, neg_d;
  logic [7:0]            opc_q, opc_d;

  logic                  is_space, is_sign, is_digit, is_lead;
  logic [DATA_WIDTH-1:0] digit;
  logic [DATA_WIDTH-1:0] first_next, second_next;
  logic [DATA_WIDTH-1:0] first_signed, second_signed;

  assign is_space = (char_code_i == CH_SPACE);
  assign is_sign  = (char_code_i == CH_PLUS) || (char_code_i == CH_MINUS);
  assign is_digit = (char_code_i >= CH_0) && (char_code_i <= CH_9);
  assign is_lead  = (phase_q == PH_LEAD);
  assign digit    = DATA_WIDTH'(char_code_i[3:0]);

  // acc * 10 + digit as two shifts and two adds
  assign first_next  = (first_q << 3) + (first_q << 1) + digit;
  assign second_next = (second_q << 3) + (second_q << 1) + digit;

  assign first_signed  = neg_q ? (DATA_WIDTH'(0) - first_q) : first_q;
  assign second_signed = neg_q ? (DATA_WIDTH'(0) - second_q) : second_q;

  assign job_a_o = first_q;
  assign job_b_o = second_signed;

  // Classify the line: an operator never reached counts as unknown.
  always_comb begin
    if (phase_q == PH_LEAD || phase_q == PH_DIG1 || phase_q == PH_PREOP) begin
      job_ctl_o.op = OP_BAD;
    end else begin
      unique case (opc_q)
        CH_PLUS:  job_ctl_o.op = OP_ADD;
        CH_MINUS: job_ctl_o.op = OP_SUB;
        CH_STAR:  job_ctl_o.op = OP_MUL;
        CH_SLASH: job_ctl_o.op = OP_DIV;
        CH_PCT:   job_ctl_o.op = OP_MOD;
        default:  job_ctl_o.op = OP_BAD;
      endcase
    end
  end

  always_comb begin
    phase_d     = phase_q;
    first_d     = first_q;
    second_d    = second_q;
    neg_d       = neg_q;
    opc_d       = opc_q;
    job_valid_o = 1'b0;
    if (char_valid_i) begin
      if (char_code_i == CH_NUL) begin
        job_valid_o = 1'b1;
        phase_d     = PH_LEAD;
        first_d     = '0;
        second_d    = '0;
        neg_d       = 1'b0;
        opc_d       = '0;
      end else begin
        unique case (phase_q)
          PH_LEAD, PH_DIG1: begin
            priority if (is_lead && is_space) begin
              phase_d = phase_q;
            end else if (is_lead && is_sign) begin
              neg_d   = (char_code_i == CH_MINUS);
              phase_d = PH_DIG1;
            end else if (is_digit) begin
              first_d = first_next;
              phase_d = PH_DIG1;
            end else if (is_space) begin
              first_d = first_signed;
              neg_d   = 1'b0;
              phase_d = PH_PREOP;
            end else begin
              first_d = first_signed;
              neg_d   = 1'b0;
              opc_d   = char_code_i;
              phase_d = PH_LEAD2;
            end
          end
          PH_PREOP: begin
            if (!is_space) begin
              opc_d   = char_code_i;
              phase_d = PH_LEAD2;
            end
          end
          PH_LEAD2: begin
            priority if (is_space) begin
              phase_d = phase_q;
            end else if (is_sign) begin
              neg_d   = (char_code_i == CH_MINUS);
              phase_d = PH_DIG2;
            end else if (is_digit) begin
              second_d = second_next;
              phase_d  = PH_DIG2;
            end else begin
              phase_d = PH_REST;
            end
          end
          PH_DIG2: begin
            if (is_digit) begin
              second_d = second_next;
            end else begin
              phase_d = PH_REST;
            end
          end
          default: phase_d = PH_REST;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_LEAD;
      first_q  <= '0;
      second_q <= '0;
      neg_q    <= 1'b0;
      opc_q    <= '0;
    end else begin
      phase_q  <= phase_d;
      first_q  <= first_d;
      second_q <= second_d;
      neg_q    <= neg_d;
      opc_q    <= opc_d;
    end
  end

endmodule

// ----- rtl/abe_queue.sv -----
module abe_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] rdata_o
);

  // Depth is a power of two so the pointers wrap on their own.
  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, rptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = slot_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= wptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rptr_q <= rptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

endmodule

// ----- rtl/abe_back.sv -----
module abe_back import abe_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  job_valid_i,
  input  job_ctl_t              job_ctl_i,
  input  logic [DATA_WIDTH-1:0] job_a_i,
  input  logic [DATA_WIDTH-1:0] job_b_i,
  output logic                  job_pop_o,
  output logic                  out_valid_o,
  input  logic                  out_pop_i,
  output logic [DATA_WIDTH-1:0] out_value_o,
  output status_e               out_status_o
);

  localparam int DW    = DATA_WIDTH;
  localparam int CNT_W = $clog2(DW);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_SIGN = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [DW-1:0]    acc_q, acc_d;
  logic [DW-1:0]    x_q, x_d;
  logic [DW-1:0]    y_q, y_d;
  logic [DW-1:0]    rem_q, rem_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             neg_q, neg_d;
  logic             mod_q, mod_d;
  status_e          st_q, st_d;

  logic             out_valid_q;
  logic [DW-1:0]    out_value_q;
  status_e          out_status_q;
  logic             out_free, out_load;

  logic             na, nb;
  logic [DW-1:0]    ma, mb, rem_sh, sel;
  logic             ge, last;

  assign na     = job_a_i[DW-1];
  assign nb     = job_b_i[DW-1];
  assign ma     = na ? (DW'(0) - job_a_i) : job_a_i;
  assign mb     = nb ? (DW'(0) - job_b_i) : job_b_i;
  assign rem_sh = {rem_q[DW-2:0], x_q[DW-1]};
  assign ge     = (rem_sh >= y_q);
  assign last   = (cnt_q == CNT_W'(DW - 1));
  assign sel    = mod_q ? rem_q : x_q;

  assign out_free = !out_valid_q || out_pop_i;

  always_comb begin
    state_d   = state_q;
    acc_d     = acc_q;
    x_d       = x_q;
    y_d       = y_q;
    rem_d     = rem_q;
    cnt_d     = cnt_q;
    neg_d     = neg_q;
    mod_d     = mod_q;
    st_d      = st_q;
    job_pop_o = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (job_valid_i) begin
          job_pop_o = 1'b1;
          st_d      = ST_OK;
          acc_d     = '0;
          cnt_d     = '0;
          state_d   = S_FIN;
          unique case (job_ctl_i.op)
            OP_ADD: acc_d = job_a_i + job_b_i;
            OP_SUB: acc_d = job_a_i - job_b_i;
            OP_MUL: begin
              x_d     = job_a_i;
              y_d     = job_b_i;
              state_d = S_MUL;
            end
            OP_DIV, OP_MOD: begin
              mod_d = (job_ctl_i.op == OP_MOD);
              neg_d = (job_ctl_i.op == OP_MOD) ? na : (na ^ nb);
              x_d   = ma;
              y_d   = mb;
              rem_d = '0;
              if (job_b_i == '0) begin
                st_d = (job_ctl_i.op == OP_MOD) ? ST_MOD0 : ST_DIV0;
              end else begin
                state_d = S_DIV;
              end
            end
            default: st_d = ST_BADOP;
          endcase
        end
      end
      S_MUL: begin
        // one bit of the multiplier per cycle
        if (y_q[0]) begin
          acc_d = acc_q + x_q;
        end
        x_d   = x_q << 1;
        y_d   = y_q >> 1;
        cnt_d = cnt_q + CNT_W'(1);
        if (last) begin
          state_d = S_FIN;
        end
      end
      S_DIV: begin
        // restoring division, one quotient bit per cycle
        rem_d = ge ? (rem_sh - y_q) : rem_sh;
        x_d   = {x_q[DW-2:0], ge};
        cnt_d = cnt_q + CNT_W'(1);
        if (last) begin
          state_d = S_SIGN;
        end
      end
      S_SIGN: begin
        acc_d   = neg_q ? (DW'(0) - sel) : sel;
        state_d = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    x_q   <= x_d;
    y_q   <= y_d;
    rem_q <= rem_d;
    cnt_q <= cnt_d;
    neg_q <= neg_d;
    mod_q <= mod_d;
    st_q  <= st_d;
    if (out_load) begin
      out_value_q  <= acc_q;
      out_status_q <= st_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_value_o  = out_value_q;
  assign out_status_o = out_status_q;

endmodule
